// ===== rtl/core/ssrt_pkg.sv =====
`default_nettype none
package ssrt_pkg;

  localparam int QBITS   = 17;
  localparam int DIV_LAT = QBITS + 1;
  localparam int NUM_W   = 35;
  localparam int NORM_W  = 33;
  localparam int ROT_W   = 18;
  localparam logic signed [ROT_W-1:0] ROT_ONE = 18'sd65536;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic signed [31:0] ss10;
    logic signed [31:0] ss20;
    logic signed [31:0] ss21;
    logic               zero;
  } side_t;

  function automatic logic signed [31:0] round_sat(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = v + 66'sd32767 + ((v >= 0) ? 66'sd1 : 66'sd0);
    t = t >>> 16;
    if (t > 66'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (t < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return t[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ssrt_qdiv.sv =====
`default_nettype none
module ssrt_qdiv (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [ssrt_pkg::NUM_W-1:0]   num_i,
  input  wire logic        [ssrt_pkg::NORM_W-1:0]  n_i,
  output logic signed      [ssrt_pkg::ROT_W-1:0]   quot_o
);
  import ssrt_pkg::*;

  logic [50:0]           rem_r [0:QBITS];
  logic [NORM_W:0]       d_r   [0:QBITS];
  logic                  sgn_r [0:QBITS];
  logic [QBITS-1:0]      q_r   [0:QBITS];
  logic signed [NUM_W-1:0] mag;

  assign mag = (num_i < 0) ? -num_i : num_i;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= (51'(mag[NORM_W-1:0]) << QBITS) + 51'(n_i);
      d_r[0]   <= {n_i, 1'b0};
      sgn_r[0] <= num_i < 0;
      q_r[0]   <= '0;
    end
  end

  for (genvar k = 0; k < QBITS; k++) begin : g_bit
    logic [50:0] sub;
    logic        take;
    assign sub  = 51'(d_r[k]) << (QBITS - 1 - k);
    assign take = rem_r[k] >= sub;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= take ? rem_r[k] - sub : rem_r[k];
        d_r[k+1]   <= d_r[k];
        sgn_r[k+1] <= sgn_r[k];
        q_r[k+1]   <= {q_r[k][QBITS-2:0], take};
      end
    end
  end

  assign quot_o = sgn_r[QBITS] ? -ROT_W'(q_r[QBITS]) : ROT_W'(q_r[QBITS]);

endmodule
`default_nettype wire

// ===== rtl/core/scale_shear_rotate_translate_matrix_unit.sv =====
`default_nettype none
// Builds the 3x4 local matrix (scale-shear times normalized quaternion rotation,
// plus translation row) in Q16.16. Fully pipelined: one item per cycle, with a
// 17-step restoring division of each rotation entry by the squared quaternion
// norm. A stall on the output holds the whole pipeline.
module scale_shear_rotate_translate_matrix_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic signed [31:0] in_scale_x,
  input  wire logic signed [31:0] in_scale_y,
  input  wire logic signed [31:0] in_scale_z,
  input  wire logic signed [31:0] in_shear_xy,
  input  wire logic signed [31:0] in_shear_xz,
  input  wire logic signed [31:0] in_shear_yz,
  input  wire logic        [63:0] in_rotation_quat,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_m00,
  output logic signed [31:0]      out_m01,
  output logic signed [31:0]      out_m02,
  output logic signed [31:0]      out_m10,
  output logic signed [31:0]      out_m11,
  output logic signed [31:0]      out_m12,
  output logic signed [31:0]      out_m20,
  output logic signed [31:0]      out_m21,
  output logic signed [31:0]      out_m22,
  output logic signed [31:0]      out_t_x,
  output logic signed [31:0]      out_t_y,
  output logic signed [31:0]      out_t_z
);
  import ssrt_pkg::*;

  logic en;
  logic signed [15:0] qx, qy, qz, qw;
  logic signed [31:0] xx_r, yy_r, zz_r, ww_r, xy_r, xz_r, yz_r, xw_r, yw_r, zw_r;
  logic signed [63:0] hxy_r, hxz_r, hyz_r;
  logic signed [31:0] p1x_r, p1y_r, p1z_r, s1x_r, s1y_r, s1z_r;
  logic v1_r;
  logic [NORM_W-1:0] n_r;
  logic signed [NUM_W-1:0] num_r [0:8];
  side_t side2_r;
  logic v2_r;
  side_t side_d_r [0:DIV_LAT-1];
  logic vd_r [0:DIV_LAT-1];
  logic signed [ROT_W-1:0] quot [0:8];
  logic signed [ROT_W-1:0] rot [0:8];
  logic signed [49:0] p_r [0:17];
  logic signed [31:0] t3x_r, t3y_r, t3z_r;
  logic v3_r;
  logic signed [NUM_W-1:0] exx, eyy, ezz, eww, exy, exz, eyz, exw, eyw, ezw, en35;
  logic [NORM_W-1:0] n_nxt;
  side_t dl;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign qx = in_rotation_quat[15:0];
  assign qy = in_rotation_quat[31:16];
  assign qz = in_rotation_quat[47:32];
  assign qw = in_rotation_quat[63:48];

  always_ff @(posedge clk) begin
    if (en) begin
      xx_r <= qx * qx; yy_r <= qy * qy; zz_r <= qz * qz; ww_r <= qw * qw;
      xy_r <= qx * qy; xz_r <= qx * qz; yz_r <= qy * qz;
      xw_r <= qx * qw; yw_r <= qy * qw; zw_r <= qz * qw;
      hxy_r <= 64'(in_shear_xy) * 64'(in_scale_y);
      hxz_r <= 64'(in_shear_xz) * 64'(in_scale_z);
      hyz_r <= 64'(in_shear_yz) * 64'(in_scale_z);
      p1x_r <= in_pos_x; p1y_r <= in_pos_y; p1z_r <= in_pos_z;
      s1x_r <= in_scale_x; s1y_r <= in_scale_y; s1z_r <= in_scale_z;
    end
  end

  assign exx = NUM_W'(xx_r); assign eyy = NUM_W'(yy_r); assign ezz = NUM_W'(zz_r);
  assign eww = NUM_W'(ww_r); assign exy = NUM_W'(xy_r); assign exz = NUM_W'(xz_r);
  assign eyz = NUM_W'(yz_r); assign exw = NUM_W'(xw_r); assign eyw = NUM_W'(yw_r);
  assign ezw = NUM_W'(zw_r);
  assign n_nxt = NORM_W'(xx_r) + NORM_W'(yy_r) + NORM_W'(zz_r) + NORM_W'(ww_r);
  assign en35  = NUM_W'(n_nxt);

  always_ff @(posedge clk) begin
    if (en) begin
      n_r      <= n_nxt;
      num_r[0] <= en35 - 2 * (eyy + ezz);
      num_r[1] <= 2 * (exy + ezw);
      num_r[2] <= 2 * (exz - eyw);
      num_r[3] <= 2 * (exy - ezw);
      num_r[4] <= en35 - 2 * (exx + ezz);
      num_r[5] <= 2 * (eyz + exw);
      num_r[6] <= 2 * (exz + eyw);
      num_r[7] <= 2 * (eyz - exw);
      num_r[8] <= en35 - 2 * (exx + eyy);
      side2_r.pos_x <= p1x_r; side2_r.pos_y <= p1y_r; side2_r.pos_z <= p1z_r;
      side2_r.sx    <= s1x_r; side2_r.sy    <= s1y_r; side2_r.sz    <= s1z_r;
      side2_r.ss10  <= round_sat(66'(hxy_r));
      side2_r.ss20  <= round_sat(66'(hxz_r));
      side2_r.ss21  <= round_sat(66'(hyz_r));
      side2_r.zero  <= n_nxt == '0;
    end
  end

  for (genvar e = 0; e < 9; e++) begin : g_div
    ssrt_qdiv u_div (
      .clk    (clk),
      .en     (en),
      .num_i  (num_r[e]),
      .n_i    (n_r),
      .quot_o (quot[e])
    );
    assign rot[e] = side_d_r[DIV_LAT-1].zero ?
                    ((e % 4 == 0) ? ROT_ONE : '0) : quot[e];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_d_r[0] <= side2_r;
      for (int s = 1; s < DIV_LAT; s++) begin
        side_d_r[s] <= side_d_r[s-1];
      end
    end
  end

  assign dl = side_d_r[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        p_r[j]      <= 50'(dl.sx)   * 50'(rot[j]);
        p_r[3 + j]  <= 50'(dl.ss10) * 50'(rot[j]);
        p_r[6 + j]  <= 50'(dl.sy)   * 50'(rot[3 + j]);
        p_r[9 + j]  <= 50'(dl.ss20) * 50'(rot[j]);
        p_r[12 + j] <= 50'(dl.ss21) * 50'(rot[3 + j]);
        p_r[15 + j] <= 50'(dl.sz)   * 50'(rot[6 + j]);
      end
      t3x_r <= dl.pos_x; t3y_r <= dl.pos_y; t3z_r <= dl.pos_z;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_m00 <= round_sat(66'(p_r[0]));
      out_m01 <= round_sat(66'(p_r[1]));
      out_m02 <= round_sat(66'(p_r[2]));
      out_m10 <= round_sat(66'(p_r[3]) + 66'(p_r[6]));
      out_m11 <= round_sat(66'(p_r[4]) + 66'(p_r[7]));
      out_m12 <= round_sat(66'(p_r[5]) + 66'(p_r[8]));
      out_m20 <= round_sat(66'(p_r[9]) + 66'(p_r[12]) + 66'(p_r[15]));
      out_m21 <= round_sat(66'(p_r[10]) + 66'(p_r[13]) + 66'(p_r[16]));
      out_m22 <= round_sat(66'(p_r[11]) + 66'(p_r[14]) + 66'(p_r[17]));
      out_t_x <= t3x_r; out_t_y <= t3y_r; out_t_z <= t3z_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      out_valid <= 1'b0;
      for (int s = 0; s < DIV_LAT; s++) begin
        vd_r[s] <= 1'b0;
      end
    end else if (en) begin
      v1_r    <= in_valid;
      v2_r    <= v1_r;
      vd_r[0] <= v2_r;
      for (int s = 1; s < DIV_LAT; s++) begin
        vd_r[s] <= vd_r[s-1];
      end
      v3_r      <= vd_r[DIV_LAT-1];
      out_valid <= v3_r;
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb;

  typedef struct packed {
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [31:0] sx, sy, sz;
    logic signed [31:0] hxy, hxz, hyz;
    logic [63:0] quat;
  } xform_t;

  typedef struct packed {
    logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [31:0] tx, ty, tz;
  } matrix_t;

  typedef struct {
    xform_t  xf;
    logic    has_fixed;
    matrix_t fixed;
  } stim_row_t;

  localparam int LATENCY = 22;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1030;
  localparam logic signed [31:0] ONE = 32'sh00010000;
  localparam logic signed [31:0] SMAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] SMIN = 32'sh80000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [31:0] in_scale_x = '0, in_scale_y = '0, in_scale_z = '0;
  logic signed [31:0] in_shear_xy = '0, in_shear_xz = '0, in_shear_yz = '0;
  logic [63:0] in_rotation_quat = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_m00, out_m01, out_m02, out_m10, out_m11, out_m12;
  logic signed [31:0] out_m20, out_m21, out_m22, out_t_x, out_t_y, out_t_z;

  scale_shear_rotate_translate_matrix_unit dut (.*);

  always #5 clk = ~clk;

  matrix_t pending_matrices[$];
  int mismatches = 0;
  int matrices_seen = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic sending_done = 1'b0;

  function automatic longint round_q16(longint v);
    longint m;
    if (v < 0) begin
      m = -v;
      return -((m + 32768) >>> 16);
    end
    return (v + 32768) >>> 16;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint norm_div(longint num, longint n);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = ((mag <<< 17) + n) / (n <<< 1);
    return (num < 0) ? -q : q;
  endfunction

  function automatic matrix_t compose_matrix(xform_t xf);
    longint x, y, z, w, n;
    longint rot[3][3];
    longint ss[3][3];
    longint acc;
    logic signed [31:0] e[9];
    matrix_t res;
    x = longint'($signed(xf.quat[15:0]));
    y = longint'($signed(xf.quat[31:16]));
    z = longint'($signed(xf.quat[47:32]));
    w = longint'($signed(xf.quat[63:48]));
    n = x*x + y*y + z*z + w*w;
    if (n == 0) begin
      foreach (rot[i, j]) rot[i][j] = (i == j) ? 64'sd65536 : 64'sd0;
    end else begin
      rot[0][0] = norm_div(n - 2*(y*y + z*z), n);
      rot[0][1] = norm_div(2*(x*y + z*w), n);
      rot[0][2] = norm_div(2*(x*z - y*w), n);
      rot[1][0] = norm_div(2*(x*y - z*w), n);
      rot[1][1] = norm_div(n - 2*(x*x + z*z), n);
      rot[1][2] = norm_div(2*(y*z + x*w), n);
      rot[2][0] = norm_div(2*(x*z + y*w), n);
      rot[2][1] = norm_div(2*(y*z - x*w), n);
      rot[2][2] = norm_div(n - 2*(x*x + y*y), n);
    end
    ss[0][0] = longint'(xf.sx); ss[0][1] = 0; ss[0][2] = 0;
    ss[1][0] = clamp32(round_q16(longint'(xf.hxy) * longint'(xf.sy)));
    ss[1][1] = longint'(xf.sy); ss[1][2] = 0;
    ss[2][0] = clamp32(round_q16(longint'(xf.hxz) * longint'(xf.sz)));
    ss[2][1] = clamp32(round_q16(longint'(xf.hyz) * longint'(xf.sz)));
    ss[2][2] = longint'(xf.sz);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += ss[i][k] * rot[k][j];
        e[i*3+j] = 32'(clamp32(round_q16(acc)));
      end
    end
    res = '{e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8],
            xf.pos_x, xf.pos_y, xf.pos_z};
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch on matrix %0d: %s got %h expected %h", matrices_seen, what, got, want);
  endtask

  function automatic logic [63:0] pack_quat(logic [15:0] qx, logic [15:0] qy,
                                            logic [15:0] qz, logic [15:0] qw);
    return {qw, qz, qy, qx};
  endfunction

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? SMAX : SMIN;
      1: return $urandom;
      2: return 32'($signed($urandom_range(0, 2*ONE*4)) - 4*ONE);
      3: return 32'($signed($urandom_range(0, 2*ONE*300)) - 300*ONE);
      default: return 32'($signed($urandom_range(0, 2*ONE)) - ONE);
    endcase
  endfunction

  function automatic logic [15:0] rand_quat_part(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 32768)) - 16384);
      default: return 16'($signed($urandom_range(0, 8)) - 4);
    endcase
  endfunction

  function automatic xform_t random_xform();
    xform_t xf;
    int qm;
    xf.pos_x = $urandom; xf.pos_y = $urandom; xf.pos_z = $urandom;
    xf.sx = rand_field(); xf.sy = rand_field(); xf.sz = rand_field();
    xf.hxy = rand_field(); xf.hxz = rand_field(); xf.hyz = rand_field();
    qm = $urandom_range(0, 2);
    xf.quat = pack_quat(rand_quat_part(qm), rand_quat_part(qm),
                        rand_quat_part(qm), rand_quat_part(qm));
    if ($urandom_range(0, 30) == 0) xf.quat = '0;
    return xf;
  endfunction

  stim_row_t directed_rows[$];

  task automatic build_directed_rows();
    xform_t xf;
    matrix_t m;
    xf = '{32'sd1, -32'sd1, SMAX, ONE, ONE, ONE, 0, 0, 0, 64'h0};
    m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 32'sd1, -32'sd1, SMAX};
    directed_rows.push_back('{xf, 1'b1, m});
    xf = '{SMIN, 0, 32'sd5, ONE, ONE, ONE, 0, 0, 0,
           pack_quat(16'h0, 16'h0, 16'h0, 16'h4000)};
    m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, SMIN, 0, 32'sd5};
    directed_rows.push_back('{xf, 1'b1, m});
    xf = '{0, 0, 0, SMAX, SMAX, SMAX, 0, 0, 0, 64'h0};
    m = '{SMAX, 0, 0, 0, SMAX, 0, 0, 0, SMAX, 0, 0, 0};
    directed_rows.push_back('{xf, 1'b1, m});
    xf = '{0, 0, 0, SMIN, SMIN, SMIN, 0, 0, 0, 64'h0};
    m = '{SMIN, 0, 0, 0, SMIN, 0, 0, 0, SMIN, 0, 0, 0};
    directed_rows.push_back('{xf, 1'b1, m});
    xf = '{0, 0, 0, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, 64'h0};
    directed_rows.push_back('{xf, 1'b0, m});
    xf = '{0, 0, 0, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN,
           pack_quat(16'h8000, 16'h0, 16'h0, 16'h0)};
    directed_rows.push_back('{xf, 1'b0, m});
    xf = '{0, 0, 0, SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, {4{16'h8000}}};
    directed_rows.push_back('{xf, 1'b0, m});
    xf = '{0, 0, 0, ONE, 2*ONE, 3*ONE, ONE, -ONE, ONE/2, {4{16'h7FFF}}};
    directed_rows.push_back('{xf, 1'b0, m});
    xf = '{0, 0, 0, ONE, ONE, ONE, 0, 0, 0, pack_quat(16'h0, 16'h0, 16'h2D41, 16'h2D41)};
    directed_rows.push_back('{xf, 1'b0, m});
    xf = '{0, 0, 0, ONE, ONE, ONE, 0, 0, 0, pack_quat(16'h0001, 16'h0, 16'h0, 16'h0)};
    directed_rows.push_back('{xf, 1'b0, m});
    xf = '{0, 0, 0, ONE, ONE, ONE, 0, 0, 0, pack_quat(16'h0, 16'hFFFF, 16'h0, 16'h0001)};
    directed_rows.push_back('{xf, 1'b0, m});
    xf = '{0, 0, 0, 32'sd1, -32'sd1, 32'sd3, 32'sh8000, -32'sh8000, 32'sh18000,
           pack_quat(16'h1234, 16'hEDCB, 16'h0F0F, 16'hF0F0)};
    directed_rows.push_back('{xf, 1'b0, m});
    xf = '{SMAX, SMIN, -32'sd1, -ONE, SMAX, -ONE, SMAX, SMIN, SMAX, {4{16'h7FFF}}};
    directed_rows.push_back('{xf, 1'b0, m});
  endtask

  task automatic send_item(xform_t xf);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= xf.pos_x; in_pos_y <= xf.pos_y; in_pos_z <= xf.pos_z;
    in_scale_x <= xf.sx; in_scale_y <= xf.sy; in_scale_z <= xf.sz;
    in_shear_xy <= xf.hxy; in_shear_xz <= xf.hxz; in_shear_yz <= xf.hyz;
    in_rotation_quat <= xf.quat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      pending_matrices.push_back(compose_matrix('{in_pos_x, in_pos_y, in_pos_z,
          in_scale_x, in_scale_y, in_scale_z, in_shear_xy, in_shear_xz, in_shear_yz,
          in_rotation_quat}));
    end
  end

  always @(posedge clk) begin
    matrix_t want;
    matrix_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_m00, out_m01, out_m02, out_m10, out_m11, out_m12,
              out_m20, out_m21, out_m22, out_t_x, out_t_y, out_t_z};
      if (pending_matrices.size() == 0) begin
        report_mismatch("m00 with no item waiting", got.m00, 'x);
      end else begin
        want = pending_matrices.pop_front();
        if (got.m00 !== want.m00) report_mismatch("m00", got.m00, want.m00);
        if (got.m01 !== want.m01) report_mismatch("m01", got.m01, want.m01);
        if (got.m02 !== want.m02) report_mismatch("m02", got.m02, want.m02);
        if (got.m10 !== want.m10) report_mismatch("m10", got.m10, want.m10);
        if (got.m11 !== want.m11) report_mismatch("m11", got.m11, want.m11);
        if (got.m12 !== want.m12) report_mismatch("m12", got.m12, want.m12);
        if (got.m20 !== want.m20) report_mismatch("m20", got.m20, want.m20);
        if (got.m21 !== want.m21) report_mismatch("m21", got.m21, want.m21);
        if (got.m22 !== want.m22) report_mismatch("m22", got.m22, want.m22);
        if (got.tx !== want.tx) report_mismatch("t_x", got.tx, want.tx);
        if (got.ty !== want.ty) report_mismatch("t_y", got.ty, want.ty);
        if (got.tz !== want.tz) report_mismatch("t_z", got.tz, want.tz);
      end
      matrices_seen++;
    end
    if (rst_n) begin
      out_stall <= (recv_idle_pct > 0) && ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (sending_done && pending_matrices.size() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int tail;
    matrix_t pred;
    build_directed_rows();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].xf);
      if (directed_rows[i].has_fixed) begin
        pred = compose_matrix(directed_rows[i].xf);
        for (int f = 0; f < 12; f++) begin
          if (pred[f*32 +: 32] !== directed_rows[i].fixed[f*32 +: 32]) begin
            report_mismatch($sformatf("directed row %0d typed-in field %0d", i, 11 - f),
                            pred[f*32 +: 32], directed_rows[i].fixed[f*32 +: 32]);
          end
        end
      end
    end
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 61 : 0;
      recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 31 : 0;
      for (int i = 0; i < RANDOM_ITEMS / 3; i++) send_item(random_xform());
    end
    in_valid <= 1'b0;
    recv_idle_pct = 0;
    sending_done = 1'b1;
    while (pending_matrices.size() != 0) @(posedge clk);
    tail = 0;
    while (tail < 2 * LATENCY) begin
      @(posedge clk);
      tail++;
    end
    $display("Sent %0d transforms (directed extremes, zero quaternions, saturation),",
             items_sent);
    $display("checked %0d matrices under sender and receiver idling.", matrices_seen);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
